// ===== sv/sidi_pkg.sv =====
// ----------------------------------------------------------------------------
// sidi_pkg
// Shared types and codes of the ticket-ordered admission lock for searchers,
// inserters and deleters.
// ----------------------------------------------------------------------------
package sidi_pkg;

  // Event kinds on the input channel.
  localparam logic KIND_REQUEST = 1'b0;
  localparam logic KIND_RELEASE = 1'b1;

  // Client classes.
  localparam logic [1:0] CLS_SEARCH  = 2'd0;
  localparam logic [1:0] CLS_INSERT  = 2'd1;
  localparam logic [1:0] CLS_DELETE  = 2'd2;
  localparam logic [1:0] CLS_UNKNOWN = 2'd3;

  // Result kinds.
  localparam logic [2:0] RK_TICKET   = 3'd0;
  localparam logic [2:0] RK_GRANT    = 3'd1;
  localparam logic [2:0] RK_REJECT   = 3'd2;
  localparam logic [2:0] RK_REL_DONE = 3'd3;
  localparam logic [2:0] RK_REL_ERR  = 3'd4;

  // Command codes that the front end hands to the back end.
  localparam logic [1:0] OP_REQ     = 2'd0;
  localparam logic [1:0] OP_REQ_BAD = 2'd1;
  localparam logic [1:0] OP_REL     = 2'd2;
  localparam logic [1:0] OP_REL_BAD = 2'd3;

  // Grants that may follow one event, and the width of their counter.
  localparam int MAX_GRANTS = 16;
  localparam int GCW        = $clog2(MAX_GRANTS + 1);

  // Searcher count at which a searcher at the head has to wait.
  localparam logic [7:0] SEARCHER_MAX = 8'd255;

  typedef struct packed {
    logic       kind;
    logic [1:0] client_class;
    logic [7:0] requester_id;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  result_kind;
    logic [15:0] ticket;
    logic [1:0]  granted_class;
    logic [7:0]  granted_requester;
    logic [7:0]  active_searchers;
    logic        active_inserters;
    logic        active_deleters;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [1:0] op;
    logic [1:0] client_class;
    logic [7:0] requester_id;
  } cmd_t;

  // One wait queue entry.
  typedef struct packed {
    logic [1:0] client_class;
    logic [7:0] requester_id;
  } entry_t;

endpackage

// ===== sv/sidi_ram.sv =====
// ----------------------------------------------------------------------------
// sidi_ram
// Generic single-write, single-read RAM with a registered read port. The
// read data holds while no read is enabled.
// ----------------------------------------------------------------------------
module sidi_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/sidi_fifo.sv =====
// ----------------------------------------------------------------------------
// sidi_fifo
// Small register-based queue with push/full and pop/empty sides. The oldest
// entry is shown on rdata while empty is low.
// ----------------------------------------------------------------------------
module sidi_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  output logic             full,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic             empty,
  output logic [WIDTH-1:0] rdata
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage needs no reset.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

// ===== sv/sidi_front.sv =====
// ----------------------------------------------------------------------------
// sidi_front
// Input side of the lock: takes each event, classifies it into a command for
// the back end and holds it in a short command queue.
// ----------------------------------------------------------------------------
module sidi_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  output logic                full,
  input  sidi_pkg::in_item_t  in_item,
  input  logic                cmd_pop,
  output logic                cmd_empty,
  output sidi_pkg::cmd_t      cmd
);

  localparam int CMD_DEPTH = 2;

  sidi_pkg::cmd_t cmd_in;
  logic [$bits(sidi_pkg::cmd_t)-1:0] cmd_bits;

  // Classify the event: request or release, with an unknown class flagged.
  always_comb begin
    cmd_in.client_class = in_item.client_class;
    cmd_in.requester_id = in_item.requester_id;
    if (in_item.kind == sidi_pkg::KIND_REQUEST) begin
      cmd_in.op = (in_item.client_class == sidi_pkg::CLS_UNKNOWN) ?
                  sidi_pkg::OP_REQ_BAD : sidi_pkg::OP_REQ;
    end else begin
      cmd_in.op = (in_item.client_class == sidi_pkg::CLS_UNKNOWN) ?
                  sidi_pkg::OP_REL_BAD : sidi_pkg::OP_REL;
    end
  end

  // Command queue between front and back.
  sidi_fifo #(
    .WIDTH ($bits(sidi_pkg::cmd_t)),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .full  (full),
    .wdata (cmd_in),
    .pop   (cmd_pop),
    .empty (cmd_empty),
    .rdata (cmd_bits)
  );

  assign cmd = sidi_pkg::cmd_t'(cmd_bits);

endmodule

// ===== sv/sidi_back.sv =====
// ----------------------------------------------------------------------------
// sidi_back
// Execution side of the lock: applies each command to the holder counts and
// the wait queue, then admits compatible requests from the queue head in
// ticket order into the result queue, one grant per cycle while it has room.
// ----------------------------------------------------------------------------
module sidi_back #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cmd_empty,
  input  sidi_pkg::cmd_t      cmd,
  output logic                cmd_pop,
  input  logic                pop,
  output logic                empty,
  output sidi_pkg::out_item_t out_item
);

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int OUT_DEPTH = 2;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RD   = 2'd1;
  localparam logic [1:0] ST_EVAL = 2'd2;

  localparam logic [PW:0]   DEPTH_W  = (PW + 1)'(QUEUE_DEPTH);
  localparam logic [PW-1:0] LAST_IDX = PW'(QUEUE_DEPTH - 1);

  logic [1:0]              state_r, state_nxt;
  logic [PW-1:0]           head_r, head_nxt;
  logic [CW-1:0]           count_r, count_nxt;
  logic [15:0]             next_ticket_r, next_ticket_nxt;
  logic [15:0]             serving_ticket_r, serving_ticket_nxt;
  logic [7:0]              scount_r, scount_nxt;
  logic                    icount_r, icount_nxt;
  logic                    dcount_r, dcount_nxt;
  logic [sidi_pkg::GCW-1:0] gcnt_r, gcnt_nxt;
  sidi_pkg::out_item_t     pend_r, pend_nxt;

  logic [PW:0]             tail_sum;
  logic [PW-1:0]           tail;
  logic [PW-1:0]           head_inc;
  logic                    queue_full;
  logic                    ram_we, ram_re;
  logic [PW-1:0]           ram_raddr;
  logic [$bits(sidi_pkg::entry_t)-1:0] ram_rdata;
  sidi_pkg::entry_t        head_entry;
  sidi_pkg::entry_t        new_entry;
  logic                    grant_fire;
  logic                    ofifo_push, ofifo_full;
  sidi_pkg::out_item_t     ofifo_wdata;
  logic [$bits(sidi_pkg::out_item_t)-1:0] ofifo_rdata;

  // Whether a request of class cls may enter with the given holders.
  function automatic logic admissible(logic [1:0] cls, logic [7:0] s, logic i, logic d);
    logic ok;
    unique case (cls)
      sidi_pkg::CLS_SEARCH: ok = !d && (s != sidi_pkg::SEARCHER_MAX);
      sidi_pkg::CLS_INSERT: ok = !d && !i;
      default:              ok = (s == 8'd0) && !i && !d;
    endcase
    return ok;
  endfunction

  // Ring addresses of the wait queue.
  assign tail_sum   = {1'b0, head_r} + (PW + 1)'(count_r);
  assign tail       = (tail_sum >= DEPTH_W) ? PW'(tail_sum - DEPTH_W) : PW'(tail_sum);
  assign head_inc   = (head_r == LAST_IDX) ? '0 : head_r + 1'b1;
  assign queue_full = (count_r == CW'(QUEUE_DEPTH));
  assign head_entry = sidi_pkg::entry_t'(ram_rdata);

  assign new_entry.client_class = cmd.client_class;
  assign new_entry.requester_id = cmd.requester_id;

  // Command sequencer: acknowledge, fetch the head, then grant while possible.
  always_comb begin
    state_nxt          = state_r;
    head_nxt           = head_r;
    count_nxt          = count_r;
    next_ticket_nxt    = next_ticket_r;
    serving_ticket_nxt = serving_ticket_r;
    scount_nxt         = scount_r;
    icount_nxt         = icount_r;
    dcount_nxt         = dcount_r;
    gcnt_nxt           = gcnt_r;
    pend_nxt           = pend_r;
    cmd_pop            = 1'b0;
    ram_we             = 1'b0;
    grant_fire         = 1'b0;
    ofifo_push         = 1'b0;
    ofifo_wdata        = pend_r;

    unique case (state_r)
      ST_IDLE: begin
        if (!cmd_empty) begin
          cmd_pop                    = 1'b1;
          gcnt_nxt                   = '0;
          state_nxt                  = ST_RD;
          pend_nxt.granted_class     = cmd.client_class;
          pend_nxt.granted_requester = cmd.requester_id;
          pend_nxt.last              = 1'b0;
          pend_nxt.ticket            = 16'd0;
          pend_nxt.result_kind       = sidi_pkg::RK_REL_ERR;
          unique case (cmd.op)
            sidi_pkg::OP_REQ: begin
              pend_nxt.ticket = next_ticket_r;
              if (queue_full) begin
                pend_nxt.result_kind = sidi_pkg::RK_REJECT;
              end else begin
                pend_nxt.result_kind = sidi_pkg::RK_TICKET;
                ram_we               = 1'b1;
                count_nxt            = count_r + 1'b1;
                next_ticket_nxt      = next_ticket_r + 16'd1;
              end
            end
            sidi_pkg::OP_REQ_BAD: begin
              pend_nxt.ticket      = next_ticket_r;
              pend_nxt.result_kind = sidi_pkg::RK_REJECT;
            end
            sidi_pkg::OP_REL: begin
              // A release at zero count stays an error.
              unique case (cmd.client_class)
                sidi_pkg::CLS_SEARCH: begin
                  if (scount_r != 8'd0) begin
                    scount_nxt           = scount_r - 8'd1;
                    pend_nxt.result_kind = sidi_pkg::RK_REL_DONE;
                  end
                end
                sidi_pkg::CLS_INSERT: begin
                  if (icount_r) begin
                    icount_nxt           = 1'b0;
                    pend_nxt.result_kind = sidi_pkg::RK_REL_DONE;
                  end
                end
                default: begin
                  if (dcount_r) begin
                    dcount_nxt           = 1'b0;
                    pend_nxt.result_kind = sidi_pkg::RK_REL_DONE;
                  end
                end
              endcase
            end
            sidi_pkg::OP_REL_BAD: begin
              pend_nxt.result_kind = sidi_pkg::RK_REL_ERR;
            end
          endcase
          pend_nxt.active_searchers = scount_nxt;
          pend_nxt.active_inserters = icount_nxt;
          pend_nxt.active_deleters  = dcount_nxt;
        end
      end
      ST_RD: begin
        state_nxt = ST_EVAL;
      end
      ST_EVAL: begin
        // The held result leaves once we know whether a grant follows it.
        if (!ofifo_full) begin
          ofifo_push = 1'b1;
          if ((count_r != '0) && (gcnt_r < sidi_pkg::GCW'(sidi_pkg::MAX_GRANTS)) &&
              admissible(head_entry.client_class, scount_r, icount_r, dcount_r)) begin
            grant_fire       = 1'b1;
            ofifo_wdata.last = 1'b0;
            unique case (head_entry.client_class)
              sidi_pkg::CLS_SEARCH: scount_nxt = scount_r + 8'd1;
              sidi_pkg::CLS_INSERT: icount_nxt = 1'b1;
              default:              dcount_nxt = 1'b1;
            endcase
            pend_nxt.result_kind       = sidi_pkg::RK_GRANT;
            pend_nxt.ticket            = serving_ticket_r;
            pend_nxt.granted_class     = head_entry.client_class;
            pend_nxt.granted_requester = head_entry.requester_id;
            pend_nxt.active_searchers  = scount_nxt;
            pend_nxt.active_inserters  = icount_nxt;
            pend_nxt.active_deleters   = dcount_nxt;
            pend_nxt.last              = 1'b0;
            serving_ticket_nxt         = serving_ticket_r + 16'd1;
            head_nxt                   = head_inc;
            count_nxt                  = count_r - 1'b1;
            gcnt_nxt                   = gcnt_r + 1'b1;
          end else begin
            ofifo_wdata.last = 1'b1;
            state_nxt        = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // The head is read after the ack write has landed, and again per grant.
  assign ram_re    = (state_r == ST_RD) || grant_fire;
  assign ram_raddr = (state_r == ST_EVAL) ? head_inc : head_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= ST_IDLE;
      head_r           <= '0;
      count_r          <= '0;
      next_ticket_r    <= '0;
      serving_ticket_r <= '0;
      scount_r         <= '0;
      icount_r         <= 1'b0;
      dcount_r         <= 1'b0;
      gcnt_r           <= '0;
    end else begin
      state_r          <= state_nxt;
      head_r           <= head_nxt;
      count_r          <= count_nxt;
      next_ticket_r    <= next_ticket_nxt;
      serving_ticket_r <= serving_ticket_nxt;
      scount_r         <= scount_nxt;
      icount_r         <= icount_nxt;
      dcount_r         <= dcount_nxt;
      gcnt_r           <= gcnt_nxt;
    end
  end

  // The held result is payload only.
  always_ff @(posedge clk) begin
    pend_r <= pend_nxt;
  end

  // Wait queue storage.
  sidi_ram #(
    .WIDTH ($bits(sidi_pkg::entry_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_wait_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (tail),
    .wdata (new_entry),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Result queue toward the output side.
  sidi_fifo #(
    .WIDTH ($bits(sidi_pkg::out_item_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (ofifo_push),
    .full  (ofifo_full),
    .wdata (ofifo_wdata),
    .pop   (pop),
    .empty (empty),
    .rdata (ofifo_rdata)
  );

  assign out_item = sidi_pkg::out_item_t'(ofifo_rdata);

  // Every issued ticket is either being served or still waiting.
  a_ticket_balance: assert property (@(posedge clk) disable iff (!rst_n)
    next_ticket_r == 16'(serving_ticket_r + 16'(count_r)))
    else $error("ticket counters disagree with the queue fill count");

  // An active deleter holds the lock alone.
  a_deleter_alone: assert property (@(posedge clk) disable iff (!rst_n)
    dcount_r |-> (scount_r == 8'd0) && !icount_r)
    else $error("deleter active together with other holders");

  // A grant only happens with a waiting entry and within the grant limit.
  a_grant_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    grant_fire |-> (count_r != '0) && (gcnt_r < sidi_pkg::GCW'(sidi_pkg::MAX_GRANTS)))
    else $error("grant without a waiting entry or past the grant limit");

  // A command taken in idle always goes on to fetch the queue head.
  a_fetch_after_ack: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE && !cmd_empty) |=> (state_r == ST_RD))
    else $error("acknowledged command did not fetch the queue head");

endmodule

// ===== sv/fifo_search_insert_delete_admission.sv =====
// ----------------------------------------------------------------------------
// fifo_search_insert_delete_admission
// Ticket-ordered admission lock for searchers, inserters and deleters.
// ----------------------------------------------------------------------------
// Each event on the input queue (a request or a release) yields one
// acknowledgement followed by zero to sixteen grants, the final result marked
// by last. Events enter a two-entry command queue, so push is taken while the
// lock is still busy with an earlier event. The execution side handles one
// event at a time in three steps: it picks up the command, reads the wait
// queue head, and evaluates. The acknowledgement enters the result queue in
// the evaluation step. Each grant repeats the evaluation step, since the wait
// queue lives in a RAM with a registered read and each grant needs the next
// head entry. A full two-entry result queue stalls the evaluation. No
// clearing pass follows reset: wait queue data is only used where written.
// ----------------------------------------------------------------------------
module fifo_search_insert_delete_admission #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  output logic                full,
  input  sidi_pkg::in_item_t  in_item,
  input  logic                pop,
  output logic                empty,
  output sidi_pkg::out_item_t out_item
);

  logic           cmd_pop;
  logic           cmd_empty;
  sidi_pkg::cmd_t cmd;

  // Intake and classification.
  sidi_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .in_item   (in_item),
    .cmd_pop   (cmd_pop),
    .cmd_empty (cmd_empty),
    .cmd       (cmd)
  );

  // Execution and admission.
  sidi_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_empty (cmd_empty),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .pop       (pop),
    .empty     (empty),
    .out_item  (out_item)
  );

endmodule
